@@ hw/rtl/som_patch_training_macros.svh @@
// Assertion macros for the SOM patch training block.
`ifndef SOM_PATCH_TRAINING_MACROS_SVH
`define SOM_PATCH_TRAINING_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every clock, disabled during reset.
`define SOM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same-cycle implication a |-> b.
`define SOM_ASSERT_IMPL(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication a |=> b.
`define SOM_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define SOM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SOM_ASSERT_IMPL(lbl, clk, rst_n, a, b, msg)
`define SOM_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

@@ hw/rtl/som_pt_pkg.sv @@
// Shared types and constants of the SOM patch training block.
`default_nettype none
package som_pt_pkg;

  localparam int PATCH_W_DEF = 8;
  localparam int PATCH_H_DEF = 8;
  localparam int UNITS_DEF   = 8;
  localparam int IMG_W_DEF   = 64;
  localparam int IMG_H_DEF   = 64;

  localparam int COORD_W = 10;
  localparam int DIST_W  = 40;
  localparam int CORR_W  = 40;
  localparam int C14_W   = 26;

  localparam logic [15:0] RATE_RST = 16'd3277;
  localparam logic [6:0]  DIM_RST  = 7'd64;

  typedef enum logic [2:0] {
    KIND_LD_W  = 3'd0,
    KIND_LD_G  = 3'd1,
    KIND_LD_P  = 3'd2,
    KIND_TRAIN = 3'd3,
    KIND_SWEEP = 3'd4,
    KIND_RD_W  = 3'd5
  } kind_e;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UPD   = 2'd1;
  localparam logic [1:0] STAT_SKIP  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  localparam logic [1:0] CFG_RATE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_CHECK,
    ST_SWCHK,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_UPD,
    ST_UDRAIN,
    ST_BLKEND,
    ST_FINISH
  } state_e;

  // Tag that travels with a weight through the update pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } upd_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/som_pt_update.sv @@
// Weight update pipeline: scaled move toward the image, with saturation.
`default_nettype none
module som_pt_update #(
  parameter int IDX_W = 9
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire som_pt_pkg::upd_ctl_t   ctl_i,
  input  wire  [IDX_W-1:0]            idx_i,
  input  wire  signed [15:0]          w_i,
  input  wire  signed [15:0]          p_i,
  input  wire  signed [15:0]          g_i,
  input  wire  [15:0]                 rate_i,
  input  wire  signed [som_pt_pkg::C14_W-1:0] c14_i,
  output som_pt_pkg::upd_ctl_t        ctl_o,
  output logic [IDX_W-1:0]            idx_o,
  output logic signed [15:0]          wdata_o
);

  som_pt_pkg::upd_ctl_t ctl_a_q, ctl_b_q, ctl_c_q;
  logic [IDX_W-1:0] idx_a_q, idx_b_q, idx_c_q;
  logic signed [15:0] w_a_q, w_b_q, w_c_q;
  logic signed [16:0] d;
  logic signed [32:0] t_d, t_q;
  logic signed [49:0] p1_d, p1_q, p1_rnd;
  logic signed [33:0] t2;
  logic signed [59:0] p2_d, p2_q, p2_rnd;
  logic signed [30:0] delta;
  logic signed [31:0] nw;

  always_comb begin
    d      = 17'(p_i) - 17'(w_i);
    t_d    = d * g_i;
    p1_d   = t_q * $signed({1'b0, rate_i});
    p1_rnd = p1_q + 50'sd32768;
    t2     = p1_rnd[49:16];
    p2_d   = t2 * c14_i;
    p2_rnd = p2_q + 60'sd268435456;
    delta  = p2_rnd[59:29];
    nw     = 32'(w_c_q) + 32'(delta);
    if (nw > 32'sd32767) begin
      wdata_o = 16'sh7fff;
    end else if (nw < -32'sd32768) begin
      wdata_o = 16'sh8000;
    end else begin
      wdata_o = nw[15:0];
    end
    ctl_o = ctl_c_q;
    idx_o = idx_c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
      ctl_c_q <= ctl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    idx_a_q <= idx_i;
    w_a_q   <= w_i;
    p1_q    <= p1_d;
    idx_b_q <= idx_a_q;
    w_b_q   <= w_a_q;
    p2_q    <= p2_d;
    idx_c_q <= idx_b_q;
    w_c_q   <= w_b_q;
  end

endmodule
`default_nettype wire

@@ hw/rtl/som_patch_training.sv @@
// Top level of the SOM patch training block: memories, scan and control.
`default_nettype none
// SOM patch training. Loads (weight, gain, pixel) and weight reads each
// return one result. A block scores every offset and unit one pixel/weight
// pair per cycle through the single read port of the weight and image
// memories, PATCH_W*PATCH_H*UNITS*PATCH_W*PATCH_H pairs (32768 at the
// defaults), then streams PATCH_W*PATCH_H*UNITS weights (512) through the
// read-modify-write update pipeline unless the block is skipped. A sweep
// repeats that per origin. A result waits in the output register while the
// next transfer is taken.
module som_patch_training #(
  parameter int PATCH_W = som_pt_pkg::PATCH_W_DEF,
  parameter int PATCH_H = som_pt_pkg::PATCH_H_DEF,
  parameter int UNITS   = som_pt_pkg::UNITS_DEF,
  parameter int IMG_W   = som_pt_pkg::IMG_W_DEF,
  parameter int IMG_H   = som_pt_pkg::IMG_H_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [1:0]        cfg_index_i,
  input  wire  [15:0]       cfg_data_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [2:0]        kind_i,
  input  wire  [11:0]       address_i,
  input  wire  signed [15:0] value_i,
  input  wire  [5:0]        block_x_i,
  input  wire  [5:0]        block_y_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [1:0]        status_o,
  output logic signed [15:0] read_value_o,
  output logic [2:0]        best_x_o,
  output logic [2:0]        best_y_o,
  output logic [2:0]        best_unit_o,
  output logic [11:0]       updated_blocks_o
);

`include "som_patch_training_macros.svh"

  localparam int N_WEIGHTS = PATCH_W * PATCH_H * UNITS;
  localparam int N_GAINS   = UNITS * UNITS;
  localparam int N_PIXELS  = IMG_W * IMG_H;
  localparam int WAW = (N_WEIGHTS > 1) ? $clog2(N_WEIGHTS) : 1;
  localparam int GAW = (N_GAINS > 1) ? $clog2(N_GAINS) : 1;
  localparam int PAW = $clog2(N_PIXELS);
  localparam int XW  = (PATCH_W > 1) ? $clog2(PATCH_W) : 1;
  localparam int YW  = (PATCH_H > 1) ? $clog2(PATCH_H) : 1;
  localparam int UW  = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int CW  = som_pt_pkg::COORD_W;
  localparam int DW  = som_pt_pkg::DIST_W;
  localparam int RW  = som_pt_pkg::CORR_W;
  localparam logic [XW-1:0] X_MAX = XW'(PATCH_W - 1);
  localparam logic [YW-1:0] Y_MAX = YW'(PATCH_H - 1);
  localparam logic [UW-1:0] U_MAX = UW'(UNITS - 1);

  // Memories; contents undefined until loaded.
  logic signed [15:0] wmem [N_WEIGHTS];
  logic signed [15:0] pmem [N_PIXELS];
  logic signed [15:0] gmem [N_GAINS];

  som_pt_pkg::state_e state_q, state_d;

  logic [15:0] rate_q;
  logic [6:0]  img_w_q, img_h_q;

  logic [2:0]  kind_q;
  logic [11:0] addr_q;
  logic [CW-1:0] sx_q, sy_q;

  // Scan/update counters: x, y, u outer; dx, dy inner (dy fastest).
  logic [XW-1:0] tx_q, tdx_q, mx_q;
  logic [YW-1:0] ty_q, tdy_q, my_q;
  logic [UW-1:0] tu_q, mu_q;

  // Scan pipeline: stage 1 has memory data, stage 2 has products.
  logic s1_v_q, s1_first_q, s1_last_q;
  logic [XW-1:0] s1_x_q, s2_x_q;
  logic [YW-1:0] s1_y_q, s2_y_q;
  logic [UW-1:0] s1_u_q, s2_u_q;
  logic s2_v_q, s2_first_q, s2_last_q;
  logic [33:0] dd_q;
  logic signed [31:0] pw_q;
  logic signed [16:0] s1_diff;
  logic signed [33:0] dd_d;
  logic [DW-1:0] acc_d_q, dsum;
  logic signed [RW-1:0] acc_c_q, csum;

  logic [DW-1:0] min_dist_q;
  logic signed [RW-1:0] max_corr_q, win_corr_q;
  logic signed [som_pt_pkg::C14_W-1:0] c14_q;
  logic signed [RW:0] c_rnd;
  logic blk_upd_q, skip;

  logic signed [15:0] w_rd_q, p_rd_q, g_rd_q;
  logic [WAW-1:0] w_ra;
  logic [PAW-1:0] p_ra;
  logic [GAW-1:0] g_ra;
  logic [CW-1:0]  pcol, prow, wiu, hiu;

  som_pt_pkg::upd_ctl_t u1_ctl_q, upd_wr;
  logic [WAW-1:0] u1_idx_q, upd_idx;
  logic signed [15:0] upd_wdata;

  logic [1:0]  res_status_q;
  logic signed [15:0] res_rd_q;
  logic [2:0]  res_bx_q, res_by_q, res_bu_q;
  logic [11:0] res_cnt_q;
  logic        out_valid_q;

  logic accept, scan_issue, upd_issue, out_load;
  logic tap_last, scan_last, upd_last, unit0, train_ok, sx_ok, sy_ok;
  logic w_we, p_we, g_we;
  logic [WAW-1:0] w_wa;
  logic signed [15:0] w_wd;

  function automatic logic [WAW-1:0] widx(input logic [XW-1:0] x,
                                         input logic [YW-1:0] y,
                                         input logic [UW-1:0] u);
    widx = WAW'(32'(y) + 32'(x) * PATCH_H + 32'(u) * (PATCH_H * PATCH_W));
  endfunction

  // ---------------- counters and range checks ----------------
  always_comb begin
    wiu = (32'(img_w_q) > IMG_W) ? CW'(IMG_W) : CW'(img_w_q);
    hiu = (32'(img_h_q) > IMG_H) ? CW'(IMG_H) : CW'(img_h_q);
    train_ok = (sx_q + CW'(2 * PATCH_W - 2) < wiu) && (sy_q + CW'(2 * PATCH_H - 2) < hiu);
    sx_ok = (sx_q + CW'(2 * PATCH_W)) < wiu;
    sy_ok = (sy_q + CW'(2 * PATCH_H)) < hiu;
    tap_last  = (tdx_q == X_MAX) && (tdy_q == Y_MAX);
    upd_last  = (tx_q == X_MAX) && (ty_q == Y_MAX) && (tu_q == U_MAX);
    scan_last = tap_last && upd_last;
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      som_pt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            som_pt_pkg::KIND_RD_W:  state_d = som_pt_pkg::ST_RDWAIT;
            som_pt_pkg::KIND_TRAIN: state_d = som_pt_pkg::ST_CHECK;
            som_pt_pkg::KIND_SWEEP: state_d = som_pt_pkg::ST_SWCHK;
            default:                state_d = som_pt_pkg::ST_FINISH;
          endcase
        end
      end
      som_pt_pkg::ST_RDWAIT: state_d = som_pt_pkg::ST_FINISH;
      som_pt_pkg::ST_CHECK: begin
        state_d = train_ok ? som_pt_pkg::ST_SCAN : som_pt_pkg::ST_FINISH;
      end
      som_pt_pkg::ST_SWCHK: begin
        if (!sx_ok) begin
          state_d = som_pt_pkg::ST_FINISH;
        end else if (sy_ok) begin
          state_d = som_pt_pkg::ST_SCAN;
        end
      end
      som_pt_pkg::ST_SCAN: begin
        if (scan_last) state_d = som_pt_pkg::ST_DRAIN;
      end
      som_pt_pkg::ST_DRAIN: begin
        if (!s1_v_q && !s2_v_q) state_d = som_pt_pkg::ST_DECIDE;
      end
      som_pt_pkg::ST_DECIDE: begin
        state_d = skip ? som_pt_pkg::ST_BLKEND : som_pt_pkg::ST_UPD;
      end
      som_pt_pkg::ST_UPD: begin
        if (upd_last) state_d = som_pt_pkg::ST_UDRAIN;
      end
      som_pt_pkg::ST_UDRAIN: begin
        if (upd_wr.valid && upd_wr.last) state_d = som_pt_pkg::ST_BLKEND;
      end
      som_pt_pkg::ST_BLKEND: begin
        state_d = (kind_q == som_pt_pkg::KIND_SWEEP) ? som_pt_pkg::ST_SWCHK
                                                     : som_pt_pkg::ST_FINISH;
      end
      som_pt_pkg::ST_FINISH: begin
        if (out_load) state_d = som_pt_pkg::ST_IDLE;
      end
      default: state_d = som_pt_pkg::ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_ready_o = (state_q == som_pt_pkg::ST_IDLE);
    accept     = in_ready_o && in_valid_i;
    scan_issue = (state_q == som_pt_pkg::ST_SCAN);
    upd_issue  = (state_q == som_pt_pkg::ST_UPD);
    out_load   = (state_q == som_pt_pkg::ST_FINISH) && (!out_valid_q || out_ready_i);
    w_we = accept && (kind_i == som_pt_pkg::KIND_LD_W) && (32'(address_i) < N_WEIGHTS);
    g_we = accept && (kind_i == som_pt_pkg::KIND_LD_G) && (32'(address_i) < N_GAINS);
    p_we = accept && (kind_i == som_pt_pkg::KIND_LD_P) && (32'(address_i) < N_PIXELS);
  end

  // ---------------- memory addressing ----------------
  always_comb begin
    if (scan_issue) begin
      pcol = sx_q + CW'(tx_q) + CW'(tdx_q);
      prow = sy_q + CW'(ty_q) + CW'(tdy_q);
      w_ra = widx(tdx_q, tdy_q, tu_q);
    end else begin
      pcol = sx_q + CW'(mx_q) + CW'(tx_q);
      prow = sy_q + CW'(my_q) + CW'(ty_q);
      w_ra = upd_issue ? widx(tx_q, ty_q, tu_q) : WAW'(address_i);
    end
    p_ra = PAW'(32'(pcol) * IMG_H + 32'(prow));
    g_ra = GAW'(32'(tu_q) + 32'(mu_q) * UNITS);
    if (upd_wr.valid) begin
      w_wa = upd_idx;
      w_wd = upd_wdata;
    end else begin
      w_wa = WAW'(address_i);
      w_wd = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we || upd_wr.valid) wmem[w_wa] <= w_wd;
    w_rd_q <= wmem[w_ra];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) pmem[PAW'(address_i)] <= value_i;
    p_rd_q <= pmem[p_ra];
  end

  always_ff @(posedge clk_i) begin
    if (g_we) gmem[GAW'(address_i)] <= value_i;
    g_rd_q <= gmem[g_ra];
  end

  // ---------------- scan datapath ----------------
  always_comb begin
    s1_diff = 17'(p_rd_q) - 17'(w_rd_q);
    dd_d    = s1_diff * s1_diff;
    dsum    = (s2_first_q ? '0 : acc_d_q) + DW'(dd_q);
    csum    = (s2_first_q ? '0 : acc_c_q) + RW'(pw_q);
    unit0   = (s2_x_q == '0) && (s2_y_q == '0) && (s2_u_q == '0);
    skip    = $signed({win_corr_q, 1'b0}) < $signed({max_corr_q[RW-1], max_corr_q});
    c_rnd   = (RW+1)'(win_corr_q) + (RW+1)'(8192);
  end

  always_ff @(posedge clk_i) begin
    pw_q    <= p_rd_q * w_rd_q;
    dd_q    <= dd_d[33:0];
    s1_x_q  <= tx_q;
    s1_y_q  <= ty_q;
    s1_u_q  <= tu_q;
    s2_x_q  <= s1_x_q;
    s2_y_q  <= s1_y_q;
    s2_u_q  <= s1_u_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s1_first_q <= (tdx_q == '0) && (tdy_q == '0);
    s1_last_q  <= tap_last;
    acc_d_q <= dsum;
    acc_c_q <= csum;
    u1_idx_q <= widx(tx_q, ty_q, tu_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      u1_ctl_q <= '0;
    end else begin
      s1_v_q         <= scan_issue;
      s2_v_q         <= s1_v_q;
      u1_ctl_q.valid <= upd_issue;
      u1_ctl_q.last  <= upd_issue && upd_last;
    end
  end

  // ---------------- update pipeline ----------------
  som_pt_update #(
    .IDX_W (WAW)
  ) u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (u1_ctl_q),
    .idx_i   (u1_idx_q),
    .w_i     (w_rd_q),
    .p_i     (p_rd_q),
    .g_i     (g_rd_q),
    .rate_i  (rate_q),
    .c14_i   (c14_q),
    .ctl_o   (upd_wr),
    .idx_o   (upd_idx),
    .wdata_o (upd_wdata)
  );

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= som_pt_pkg::ST_IDLE;
      rate_q       <= som_pt_pkg::RATE_RST;
      img_w_q      <= som_pt_pkg::DIM_RST;
      img_h_q      <= som_pt_pkg::DIM_RST;
      kind_q       <= '0;
      addr_q       <= '0;
      sx_q         <= '0;
      sy_q         <= '0;
      tx_q         <= '0;
      ty_q         <= '0;
      tu_q         <= '0;
      tdx_q        <= '0;
      tdy_q        <= '0;
      mx_q         <= '0;
      my_q         <= '0;
      mu_q         <= '0;
      min_dist_q   <= '0;
      max_corr_q   <= '0;
      win_corr_q   <= '0;
      c14_q        <= '0;
      blk_upd_q    <= 1'b0;
      res_status_q <= som_pt_pkg::STAT_OK;
      res_rd_q     <= '0;
      res_bx_q     <= '0;
      res_by_q     <= '0;
      res_bu_q     <= '0;
      res_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      status_o         <= '0;
      read_value_o     <= '0;
      best_x_o         <= '0;
      best_y_o         <= '0;
      best_unit_o      <= '0;
      updated_blocks_o <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          som_pt_pkg::CFG_RATE:   rate_q  <= cfg_data_i;
          som_pt_pkg::CFG_WIDTH:  img_w_q <= cfg_data_i[6:0];
          som_pt_pkg::CFG_HEIGHT: img_h_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end

      if (accept) begin
        kind_q       <= kind_i;
        addr_q       <= address_i;
        sx_q         <= (kind_i == som_pt_pkg::KIND_SWEEP) ? '0 : CW'(block_x_i);
        sy_q         <= (kind_i == som_pt_pkg::KIND_SWEEP) ? '0 : CW'(block_y_i);
        res_status_q <= som_pt_pkg::STAT_OK;
        res_rd_q     <= '0;
        res_bx_q     <= '0;
        res_by_q     <= '0;
        res_bu_q     <= '0;
        res_cnt_q    <= '0;
      end

      case (state_q)
        som_pt_pkg::ST_RDWAIT: begin
          if (32'(addr_q) < N_WEIGHTS) res_rd_q <= w_rd_q;
        end
        som_pt_pkg::ST_CHECK: begin
          if (!train_ok) res_status_q <= som_pt_pkg::STAT_RANGE;
        end
        som_pt_pkg::ST_SWCHK: begin
          if (sx_ok && !sy_ok) begin
            sx_q <= sx_q + CW'(3);
            sy_q <= '0;
          end
        end
        som_pt_pkg::ST_DECIDE: begin
          c14_q     <= c_rnd[RW-1:14];
          blk_upd_q <= !skip;
          if (kind_q == som_pt_pkg::KIND_TRAIN) begin
            res_status_q <= skip ? som_pt_pkg::STAT_SKIP : som_pt_pkg::STAT_UPD;
            res_bx_q     <= 3'(mx_q);
            res_by_q     <= 3'(my_q);
            res_bu_q     <= 3'(mu_q);
          end
        end
        som_pt_pkg::ST_BLKEND: begin
          // Only a sweep reports a block count.
          if ((kind_q == som_pt_pkg::KIND_SWEEP) && blk_upd_q && (res_cnt_q != 12'hfff))
            res_cnt_q <= res_cnt_q + 12'd1;
          sy_q <= sy_q + CW'(3);
        end
        default: ;
      endcase

      // Counters: cleared on entry to a scan, stepped while issuing.
      if (state_d == som_pt_pkg::ST_SCAN && state_q != som_pt_pkg::ST_SCAN) begin
        tx_q       <= '0;
        ty_q       <= '0;
        tu_q       <= '0;
        tdx_q      <= '0;
        tdy_q      <= '0;
        max_corr_q <= -(RW'(1) <<< 28);
      end else if (scan_issue) begin
        if (tdy_q != Y_MAX) begin
          tdy_q <= tdy_q + YW'(1);
        end else begin
          tdy_q <= '0;
          if (tdx_q != X_MAX) begin
            tdx_q <= tdx_q + XW'(1);
          end else begin
            tdx_q <= '0;
            if (tu_q != U_MAX) begin
              tu_q <= tu_q + UW'(1);
            end else begin
              tu_q <= '0;
              if (ty_q != Y_MAX) begin
                ty_q <= ty_q + YW'(1);
              end else begin
                ty_q <= '0;
                tx_q <= (tx_q != X_MAX) ? tx_q + XW'(1) : '0;
              end
            end
          end
        end
      end else if (upd_issue) begin
        if (tu_q != U_MAX) begin
          tu_q <= tu_q + UW'(1);
        end else begin
          tu_q <= '0;
          if (ty_q != Y_MAX) begin
            ty_q <= ty_q + YW'(1);
          end else begin
            ty_q <= '0;
            tx_q <= (tx_q != X_MAX) ? tx_q + XW'(1) : '0;
          end
        end
      end

      // End of one unit's sum: first strict minimum wins, track max corr.
      if (s2_v_q && s2_last_q) begin
        if ($signed(csum) > max_corr_q) max_corr_q <= csum;
        if (unit0 || (dsum < min_dist_q)) begin
          min_dist_q <= dsum;
          win_corr_q <= csum;
          mx_q       <= s2_x_q;
          my_q       <= s2_y_q;
          mu_q       <= s2_u_q;
        end
      end

      if (out_load) begin
        out_valid_q      <= 1'b1;
        status_o         <= res_status_q;
        read_value_o     <= res_rd_q;
        best_x_o         <= res_bx_q;
        best_y_o         <= res_by_q;
        best_unit_o      <= res_bu_q;
        updated_blocks_o <= res_cnt_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `SOM_ASSERT_IMPL(a_upd_wr_state, clk_i, rst_ni, upd_wr.valid, (state_q == som_pt_pkg::ST_UPD) || (state_q == som_pt_pkg::ST_UDRAIN), "weight write-back outside update phase")
  `SOM_ASSERT_IMPL(a_scan_pipe_state, clk_i, rst_ni, s2_v_q, (state_q == som_pt_pkg::ST_SCAN) || (state_q == som_pt_pkg::ST_DRAIN), "scan pipeline busy outside scan")
  `SOM_ASSERT_IMPL(a_idle_empty, clk_i, rst_ni, in_ready_o, !s1_v_q && !s2_v_q && !u1_ctl_q.valid && !upd_wr.valid, "transfer taken with pipeline busy")
  `SOM_ASSERT_NEXT(a_finish_loads, clk_i, rst_ni, out_load, out_valid_q, "result not presented after finish")

endmodule
`default_nettype wire
